@@ design/cebm_pkg.sv @@
// cebm_pkg: shared constants, operation codes and address helper for the
// circle erase bitmap mask. Depends on nothing; used by the top level and
// its checker.
`timescale 1ns / 1ps
`default_nettype none

package cebm_pkg;

  // map geometry
  localparam int MAP_WIDTH  = 512;
  localparam int MAP_HEIGHT = 256;
  localparam int CELL_COUNT = MAP_WIDTH * MAP_HEIGHT;

  localparam int XW     = (MAP_WIDTH  > 1) ? $clog2(MAP_WIDTH)  : 1;
  localparam int YW     = (MAP_HEIGHT > 1) ? $clog2(MAP_HEIGHT) : 1;
  localparam int CELL_W = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;

  // field widths
  localparam int OP_W    = 2;
  localparam int CX_W    = 11;
  localparam int CY_W    = 10;
  localparam int ALPHA_W = 8;
  localparam int RAD_W   = 8;
  localparam int COUNT_W = 18;

  localparam logic [ALPHA_W-1:0] HOLE_ALPHA_LIMIT = 8'd128;

  // operation codes
  localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
  localparam logic [OP_W-1:0] OP_ERASE = 2'd1;
  localparam logic [OP_W-1:0] OP_QUERY = 2'd2;

  // row-major cell index
  function automatic logic [CELL_W-1:0] cell_of(input logic [XW-1:0] x,
                                                input logic [YW-1:0] y);
    return CELL_W'(CELL_W'(y) * CELL_W'(MAP_WIDTH) + CELL_W'(x));
  endfunction

endpackage

`default_nettype wire

@@ design/circle_erase_bitmap_mask.sv @@
// A load goes from IDLE to FINISH, a query through QREAD to FINISH, and an erase
// through SETUP, WALK over the clamped bounding box and DRAIN to FINISH (straight
// from SETUP to FINISH when the box misses the map). The result register loads in
// FINISH, and the next request is taken once it has; the walk visits one pixel per cycle.
// Reset: synchronous; afterwards the mask is cleared one cell a cycle, all 131072
// cells with in_stall high, before the first request is taken.
//
// circle_erase_bitmap_mask: one-bit hole mask held in a synchronous memory,
// with load, circle erase and query requests. Depends on cebm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module circle_erase_bitmap_mask (
  input  logic                                   clk,
  input  logic                                   rst,
  // request channel
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic [cebm_pkg::OP_W-1:0]              operation,
  input  logic signed [cebm_pkg::CX_W-1:0]       coord_x,
  input  logic signed [cebm_pkg::CY_W-1:0]       coord_y,
  input  logic [cebm_pkg::ALPHA_W-1:0]           alpha,
  input  logic [cebm_pkg::RAD_W-1:0]             radius,
  // result channel
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic                                   solid,
  output logic [cebm_pkg::COUNT_W-1:0]           destroyed_count
);

  localparam int XW     = cebm_pkg::XW;
  localparam int YW     = cebm_pkg::YW;
  localparam int CELL_W = cebm_pkg::CELL_W;
  localparam int CX_W   = cebm_pkg::CX_W;
  localparam int CY_W   = cebm_pkg::CY_W;
  localparam int RAD_W  = cebm_pkg::RAD_W;
  localparam int CNT_W  = cebm_pkg::COUNT_W;
  localparam int EX_W   = CX_W + 1;   // centre column +/- radius
  localparam int EY_W   = CY_W + 1;   // centre row +/- radius
  localparam int SQ_W   = 2 * RAD_W;  // square of an offset within the box

  // sequencer states
  localparam logic [2:0] ST_CLEAR  = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_QREAD  = 3'd2;
  localparam logic [2:0] ST_SETUP  = 3'd3;
  localparam logic [2:0] ST_WALK   = 3'd4;
  localparam logic [2:0] ST_DRAIN  = 3'd5;
  localparam logic [2:0] ST_FINISH = 3'd6;

  // ---------------------------------------------------------------------
  // control and working registers
  // ---------------------------------------------------------------------
  logic [2:0]               state;
  logic [CELL_W-1:0]        clr_addr;

  logic signed [CX_W-1:0]   cx;
  logic signed [CY_W-1:0]   cy;
  logic [RAD_W-1:0]         r;
  logic [SQ_W-1:0]          r2;
  logic [XW-1:0]            x0;
  logic [XW-1:0]            x1;
  logic [YW-1:0]            y1;
  logic [XW-1:0]            wx;
  logic [YW-1:0]            wy;

  // second stage of the erase walk: memory data lines up with these
  logic                     p1_valid;
  logic [CELL_W-1:0]        p1_addr;
  logic [SQ_W-1:0]          p1_dx2;
  logic [SQ_W-1:0]          p1_dy2;

  logic                     q_hit;
  logic                     res_solid;
  logic [CNT_W-1:0]         count;

  // ---------------------------------------------------------------------
  // mask memory: one write port, one registered read port
  // ---------------------------------------------------------------------
  logic                     mem [cebm_pkg::CELL_COUNT];
  logic                     rd_data;
  logic [CELL_W-1:0]        rd_addr;
  logic                     wr_en;
  logic [CELL_W-1:0]        wr_addr;
  logic                     wr_data;

  // ---------------------------------------------------------------------
  // request decode
  // ---------------------------------------------------------------------
  logic                     accept;
  logic                     req_in_map;
  logic [CELL_W-1:0]        req_cell;

  assign in_stall = (state != ST_IDLE);
  assign accept   = in_valid && !in_stall;

  // in map: non-negative and below the map size on both axes
  assign req_in_map = !coord_x[CX_W-1]
                   && (32'(coord_x[CX_W-2:0]) < cebm_pkg::MAP_WIDTH)
                   && !coord_y[CY_W-1]
                   && (32'(coord_y[CY_W-2:0]) < cebm_pkg::MAP_HEIGHT);
  assign req_cell   = cebm_pkg::cell_of(coord_x[XW-1:0], coord_y[YW-1:0]);

  // ---------------------------------------------------------------------
  // bounding box of the circle, clamped to the map (used in setup)
  // ---------------------------------------------------------------------
  logic [EX_W-1:0]          ex_lo;
  logic [EX_W-1:0]          ex_hi;
  logic [EY_W-1:0]          ey_lo;
  logic [EY_W-1:0]          ey_hi;
  logic                     box_empty;
  logic [XW-1:0]            x0_clamp;
  logic [XW-1:0]            x1_clamp;
  logic [YW-1:0]            y0_clamp;
  logic [YW-1:0]            y1_clamp;

  assign ex_lo = EX_W'(cx) - EX_W'(r);
  assign ex_hi = EX_W'(cx) + EX_W'(r);
  assign ey_lo = EY_W'(cy) - EY_W'(r);
  assign ey_hi = EY_W'(cy) + EY_W'(r);

  // box misses the map when one side ends before the map starts or
  // starts after the map ends
  assign box_empty =
      ex_hi[EX_W-1]
   || (!ex_lo[EX_W-1] && (32'(ex_lo[EX_W-2:0]) > cebm_pkg::MAP_WIDTH - 1))
   || ey_hi[EY_W-1]
   || (!ey_lo[EY_W-1] && (32'(ey_lo[EY_W-2:0]) > cebm_pkg::MAP_HEIGHT - 1));

  assign x0_clamp = ex_lo[EX_W-1] ? '0 : ex_lo[XW-1:0];
  assign y0_clamp = ey_lo[EY_W-1] ? '0 : ey_lo[YW-1:0];
  assign x1_clamp = (32'(ex_hi[EX_W-2:0]) > cebm_pkg::MAP_WIDTH - 1)
                  ? XW'(cebm_pkg::MAP_WIDTH - 1) : ex_hi[XW-1:0];
  assign y1_clamp = (32'(ey_hi[EY_W-2:0]) > cebm_pkg::MAP_HEIGHT - 1)
                  ? YW'(cebm_pkg::MAP_HEIGHT - 1) : ey_hi[YW-1:0];

  // ---------------------------------------------------------------------
  // walk stage 0: offsets from the centre, squared and registered
  // (inside the box every offset is within +/- radius)
  // ---------------------------------------------------------------------
  logic [EX_W-1:0]          dx_full;
  logic [EY_W-1:0]          dy_full;
  logic signed [RAD_W:0]    dx;
  logic signed [RAD_W:0]    dy;
  logic signed [2*RAD_W+1:0] dx_sq;
  logic signed [2*RAD_W+1:0] dy_sq;

  assign dx_full = EX_W'(wx) - EX_W'(cx);
  assign dy_full = EY_W'(wy) - EY_W'(cy);
  assign dx      = dx_full[RAD_W:0];
  assign dy      = dy_full[RAD_W:0];
  assign dx_sq   = dx * dx;
  assign dy_sq   = dy * dy;

  // ---------------------------------------------------------------------
  // walk stage 1: circle test against the old mark, set the hole
  // ---------------------------------------------------------------------
  logic                     p1_inside;
  logic                     p1_newhole;

  assign p1_inside  = ((SQ_W+1)'(p1_dx2) + (SQ_W+1)'(p1_dy2)) <= (SQ_W+1)'(r2);
  assign p1_newhole = p1_valid && p1_inside && !rd_data;

  // ---------------------------------------------------------------------
  // memory port selection
  // ---------------------------------------------------------------------
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = req_cell;
    wr_data = 1'b0;
    if (state == ST_CLEAR) begin
      wr_en   = 1'b1;
      wr_addr = clr_addr;
    end else if (p1_newhole) begin
      wr_en   = 1'b1;
      wr_addr = p1_addr;
      wr_data = 1'b1;
    end else if (accept && (operation == cebm_pkg::OP_LOAD) && req_in_map) begin
      wr_en   = 1'b1;
      wr_data = (alpha < cebm_pkg::HOLE_ALPHA_LIMIT);
    end
  end

  assign rd_addr = (state == ST_WALK) ? cebm_pkg::cell_of(wx, wy) : req_cell;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  // ---------------------------------------------------------------------
  // sequencer
  // ---------------------------------------------------------------------
  logic                     out_load;

  assign out_load = (state == ST_FINISH) && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
      p1_valid <= 1'b0;
    end else begin
      p1_valid <= (state == ST_WALK);
      case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == CELL_W'(cebm_pkg::CELL_COUNT - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            case (operation)
              cebm_pkg::OP_ERASE: state <= ST_SETUP;
              cebm_pkg::OP_QUERY: state <= ST_QREAD;
              default:            state <= ST_FINISH;
            endcase
          end
        end
        ST_QREAD: state <= ST_FINISH;
        ST_SETUP: state <= box_empty ? ST_FINISH : ST_WALK;
        ST_WALK: begin
          if ((wx == x1) && (wy == y1)) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: state <= ST_FINISH;
        ST_FINISH: begin
          if (out_load) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_CLEAR;
      endcase
    end
  end

  // working registers, no reset needed
  always_ff @(posedge clk) begin
    if (accept) begin
      cx        <= coord_x;
      cy        <= coord_y;
      r         <= radius;
      q_hit     <= req_in_map;
      res_solid <= 1'b0;
      count     <= '0;
    end
    if (state == ST_SETUP) begin
      r2 <= SQ_W'(r) * SQ_W'(r);
      x0 <= x0_clamp;
      x1 <= x1_clamp;
      y1 <= y1_clamp;
      wx <= x0_clamp;
      wy <= y0_clamp;
    end
    if (state == ST_WALK) begin
      // row-major raster over the box
      if (wx == x1) begin
        wx <= x0;
        wy <= wy + 1'b1;
      end else begin
        wx <= wx + 1'b1;
      end
      p1_addr <= cebm_pkg::cell_of(wx, wy);
      p1_dx2  <= dx_sq[SQ_W-1:0];
      p1_dy2  <= dy_sq[SQ_W-1:0];
    end
    if (state == ST_QREAD) begin
      res_solid <= q_hit && !rd_data;
    end
    if (p1_newhole) begin
      count <= count + 1'b1;
    end
  end

  // ---------------------------------------------------------------------
  // result register
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      solid           <= res_solid;
      destroyed_count <= count;
    end
  end

endmodule

`default_nettype wire

@@ design/cebm_checker.sv @@
// cebm_checker: port-level assertions for circle_erase_bitmap_mask, bound
// to the top level. Depends on cebm_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

module cebm_checker (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  input  logic                                   in_stall,
  input  logic                                   out_valid,
  input  logic                                   out_stall,
  input  logic                                   solid,
  input  logic [cebm_pkg::COUNT_W-1:0]           destroyed_count
);

  // mask clear keeps requests out right after reset
  a_clear_after_reset: assert property (@(posedge clk)
    rst |=> (in_stall && !out_valid))
    else $error("requests taken or result shown right after reset");

  // one request at a time: an accepted request closes the input
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input open in the cycle after a request was taken");

  // a held result keeps its value
  a_result_held: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=>
      (out_valid && $stable(solid) && $stable(destroyed_count)))
    else $error("stalled result changed");

  // a result is either a query answer or an erase count, never both
  a_result_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(solid && (destroyed_count != '0)))
    else $error("result carries both solid and a count");

  // no count beyond the map size
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (32'(destroyed_count) <= cebm_pkg::CELL_COUNT))
    else $error("destroyed count beyond the map size");

endmodule

bind circle_erase_bitmap_mask cebm_checker u_cebm_checker (.*);

`default_nettype wire

@@ verif/circle_erase_bitmap_mask_tb.sv @@
// circle_erase_bitmap_mask_tb: self-checking bench for the hole mask block.
// A directed table is followed by random load, erase and query requests under
// sender gaps and receiver stalls. Depends on cebm_pkg and circle_erase_bitmap_mask.
`timescale 1ns / 1ps

module circle_erase_bitmap_mask_tb;

  localparam int OP_W      = cebm_pkg::OP_W;
  localparam int CX_W      = cebm_pkg::CX_W;
  localparam int CY_W      = cebm_pkg::CY_W;
  localparam int ALPHA_W   = cebm_pkg::ALPHA_W;
  localparam int RAD_W     = cebm_pkg::RAD_W;
  localparam int COUNT_W   = cebm_pkg::COUNT_W;
  localparam int MAP_W     = cebm_pkg::MAP_WIDTH;
  localparam int MAP_H     = cebm_pkg::MAP_HEIGHT;
  localparam int CELLS     = cebm_pkg::CELL_COUNT;
  localparam int RAND_REQS = 550;

  localparam logic [OP_W-1:0] OP_LOAD  = cebm_pkg::OP_LOAD;
  localparam logic [OP_W-1:0] OP_ERASE = cebm_pkg::OP_ERASE;
  localparam logic [OP_W-1:0] OP_QUERY = cebm_pkg::OP_QUERY;
  // the fourth code has no operation behind it, the block just answers zeros
  localparam logic [OP_W-1:0] OP_SPARE = 2'd3;

  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

  typedef struct {
    logic [OP_W-1:0]         op;
    logic signed [CX_W-1:0]  x;
    logic signed [CY_W-1:0]  y;
    logic [ALPHA_W-1:0]      alpha;
    logic [RAD_W-1:0]        radius;
  } mask_req_t;

  typedef struct {
    logic               solid;
    logic [COUNT_W-1:0] count;
  } mask_res_t;

  typedef struct {
    mask_req_t req;
    bit        typed;
    mask_res_t want;
  } dir_row_t;

  // block inputs, all known from time zero
  logic                    clk       = 1'b0;
  logic                    rst       = 1'b1;
  logic                    in_valid  = 1'b0;
  logic [OP_W-1:0]         operation = '0;
  logic signed [CX_W-1:0]  coord_x   = '0;
  logic signed [CY_W-1:0]  coord_y   = '0;
  logic [ALPHA_W-1:0]      alpha     = '0;
  logic [RAD_W-1:0]        radius    = '0;
  logic                    out_stall = 1'b0;

  // block outputs
  logic                    in_stall;
  logic                    out_valid;
  logic                    solid;
  logic [COUNT_W-1:0]      destroyed_count;

  circle_erase_bitmap_mask u_top (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .operation       (operation),
    .coord_x         (coord_x),
    .coord_y         (coord_y),
    .alpha           (alpha),
    .radius          (radius),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .solid           (solid),
    .destroyed_count (destroyed_count)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predicted hole mask, 1 = hole, cleared like the block after reset
  bit          hole_bits [CELLS];
  mask_res_t   owed_results [$];
  dir_row_t    directed_rows [$];
  idle_mode_t  idle_mode = IDLE_NONE;

  int          mismatch_count = 0;
  int          result_count   = 0;
  int          n_load = 0, n_erase = 0, n_query = 0, n_spare = 0;
  longint      pixels_erased  = 0;
  longint      cycles         = 0;
  // grows with every request by its worst-case cost, clearing pass up front
  longint      cycle_budget   = 4 * CELLS + 20000;

  function automatic bit on_map(int x, int y);
    return x >= 0 && x < MAP_W && y >= 0 && y < MAP_H;
  endfunction

  // bounding box of a circle, clamped to the map; empty when x0 > x1 or y0 > y1
  function automatic void clamp_box(input int cx, input int cy, input int rad,
                                    output int x0, output int x1,
                                    output int y0, output int y1);
    x0 = (cx - rad < 0) ? 0 : cx - rad;
    y0 = (cy - rad < 0) ? 0 : cy - rad;
    x1 = (cx + rad > MAP_W - 1) ? MAP_W - 1 : cx + rad;
    y1 = (cy + rad > MAP_H - 1) ? MAP_H - 1 : cy + rad;
  endfunction

  // applies one request to the predicted mask and returns its answer
  function automatic mask_res_t mask_step(mask_req_t req);
    mask_res_t res;
    int        cx, cy, rad, x0, x1, y0, y1, dx, dy;
    res.solid = 1'b0;
    res.count = '0;
    cx  = int'(req.x);
    cy  = int'(req.y);
    rad = int'(req.radius);
    case (req.op)
      OP_LOAD: begin
        if (on_map(cx, cy))
          hole_bits[cy * MAP_W + cx] = (req.alpha < cebm_pkg::HOLE_ALPHA_LIMIT);
      end
      OP_ERASE: begin
        clamp_box(cx, cy, rad, x0, x1, y0, y1);
        for (int py = y0; py <= y1; py++) begin
          for (int px = x0; px <= x1; px++) begin
            dx = px - cx;
            dy = py - cy;
            if (dx * dx + dy * dy <= rad * rad && !hole_bits[py * MAP_W + px]) begin
              hole_bits[py * MAP_W + px] = 1'b1;
              res.count = res.count + 1'b1;
            end
          end
        end
      end
      OP_QUERY: begin
        if (on_map(cx, cy))
          res.solid = !hole_bits[cy * MAP_W + cx];
      end
      default: ;
    endcase
    return res;
  endfunction

  function automatic void add_row(logic [OP_W-1:0] op, int x, int y, int a, int r,
                                  bit typed = 1'b0, int s = 0, int c = 0);
    dir_row_t row;
    row.req.op     = op;
    row.req.x      = CX_W'(x);
    row.req.y      = CY_W'(y);
    row.req.alpha  = ALPHA_W'(a);
    row.req.radius = RAD_W'(r);
    row.typed      = typed;
    row.want.solid = 1'(s);
    row.want.count = COUNT_W'(c);
    directed_rows.push_back(row);
  endfunction

  function automatic int send_idle_pct();
    case (idle_mode)
      IDLE_SEND: return 83;
      IDLE_BOTH: return 18;
      default:   return 0;
    endcase
  endfunction

  function automatic int recv_stall_pct();
    case (idle_mode)
      IDLE_RECV: return 83;
      IDLE_BOTH: return 18;
      default:   return 0;
    endcase
  endfunction

  // mostly in the map, some along the edges, some anywhere in the field range
  function automatic int pick_coord(int span, int bits);
    case ($urandom_range(9))
      0, 1:    return int'($urandom_range((1 << bits) - 1)) - (1 << (bits - 1));
      2:       return $urandom_range(1) ? int'($urandom_range(24)) - 12
                                        : span - 12 + int'($urandom_range(24));
      default: return int'($urandom_range(span - 1));
    endcase
  endfunction

  function automatic mask_req_t random_req();
    mask_req_t req;
    int        pick;
    pick = $urandom_range(99);
    if (pick < 35)      req.op = OP_LOAD;
    else if (pick < 65) req.op = OP_ERASE;
    else if (pick < 95) req.op = OP_QUERY;
    else                req.op = OP_SPARE;
    req.x     = CX_W'(pick_coord(MAP_W, CX_W));
    req.y     = CY_W'(pick_coord(MAP_H, CY_W));
    req.alpha = ALPHA_W'($urandom_range(255));
    if (req.op == OP_ERASE) begin
      // big circles walk up to the whole map, so keep them rare
      pick = $urandom_range(99);
      if (pick == 0)     req.radius = RAD_W'($urandom_range(255));
      else if (pick < 10) req.radius = RAD_W'($urandom_range(40, 11));
      else               req.radius = RAD_W'($urandom_range(10));
    end else begin
      req.radius = RAD_W'($urandom_range(255));
    end
    return req;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch on result %0d: %s got %0d want %0d", result_count, what, got, want);
    mismatch_count++;
  endtask

  // called at a falling edge, returns at the falling edge after the accept
  task automatic send_request(input mask_req_t req, input bit typed, input mask_res_t want);
    mask_res_t got;
    int        x0, x1, y0, y1;
    clamp_box(int'(req.x), int'(req.y), int'(req.radius), x0, x1, y0, y1);
    cycle_budget += 400;
    if (req.op == OP_ERASE && x0 <= x1 && y0 <= y1)
      cycle_budget += 4 * (x1 - x0 + 1) * (y1 - y0 + 1);
    // sender gap, valid dropped one cycle at a time
    while ($urandom_range(99) < send_idle_pct()) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid  <= 1'b1;
    operation <= req.op;
    coord_x   <= req.x;
    coord_y   <= req.y;
    alpha     <= req.alpha;
    radius    <= req.radius;
    // hold the request until an edge with stall low takes it
    @(posedge clk);
    while (in_stall) @(posedge clk);
    got = mask_step(req);
    owed_results.push_back(typed ? want : got);
    case (req.op)
      OP_LOAD:  n_load++;
      OP_ERASE: begin
        n_erase++;
        pixels_erased += got.count;
      end
      OP_QUERY: n_query++;
      default:  n_spare++;
    endcase
    @(negedge clk);
  endtask

  task automatic check_result(input logic got_solid, input logic [COUNT_W-1:0] got_count);
    mask_res_t want;
    result_count++;
    if (owed_results.size() == 0) begin
      report_mismatch("result with no request owed", 1, 0);
      return;
    end
    want = owed_results.pop_front();
    if (got_solid !== want.solid)
      report_mismatch("solid", got_solid, want.solid);
    if (got_count !== want.count)
      report_mismatch("destroyed_count", got_count, want.count);
  endtask

  // receiver stalls, redrawn every cycle
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct());
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      check_result(solid, destroyed_count);
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > cycle_budget) begin
      $display("timeout after %0d cycles, %0d results still owed",
               cycles, owed_results.size());
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    mask_req_t req;
    mask_res_t none;
    int        counted;
    none.solid = 1'b0;
    none.count = '0;
    counted    = 0;

    // directed table: op, x, y, alpha, radius, typed, solid, count
    // fresh mask is solid everywhere, off-map queries read 0
    add_row(OP_QUERY,     0,    0,   0,   0, 1'b1, 1, 0);
    add_row(OP_QUERY,   511,  255,   0,   0, 1'b1, 1, 0);
    add_row(OP_QUERY,    -1,    0,   0,   0, 1'b1, 0, 0);
    add_row(OP_QUERY,   512,    0,   0,   0, 1'b1, 0, 0);
    add_row(OP_QUERY,     0,   -1,   0,   0, 1'b1, 0, 0);
    add_row(OP_QUERY,     0,  256,   0,   0, 1'b1, 0, 0);
    add_row(OP_QUERY, -1024, -512, 255, 255, 1'b1, 0, 0);
    add_row(OP_QUERY,  1023,  511, 255, 255, 1'b1, 0, 0);
    // alpha threshold on both sides of 128
    add_row(OP_LOAD,      0,    0, 127,   0, 1'b1, 0, 0);
    add_row(OP_QUERY,     0,    0,   0,   0, 1'b1, 0, 0);
    add_row(OP_LOAD,      0,    0, 128, 255, 1'b1, 0, 0);
    add_row(OP_QUERY,     0,    0,   0,   0, 1'b1, 1, 0);
    add_row(OP_LOAD,    511,  255,   0,   0, 1'b1, 0, 0);
    add_row(OP_QUERY,   511,  255, 255,   0, 1'b1, 0, 0);
    // load off the map is dropped
    add_row(OP_LOAD,     -5,    3,   0,   0, 1'b1, 0, 0);
    // spare code with every field at its top
    add_row(OP_SPARE,    -1,   -1, 255, 255, 1'b1, 0, 0);
    // zero radius hits only the centre, once
    add_row(OP_ERASE,    10,   10,   0,   0, 1'b1, 0, 1);
    add_row(OP_ERASE,    10,   10,   0,   0, 1'b1, 0, 0);
    add_row(OP_ERASE,    -1,   -1,   0,   0, 1'b1, 0, 0);
    // boxes that miss the map entirely
    add_row(OP_ERASE,  -300,  100,   0,  10, 1'b1, 0, 0);
    add_row(OP_ERASE,  1023,  511,   0, 255, 1'b1, 0, 0);
    add_row(OP_ERASE, -1024, -512,   0, 255, 1'b1, 0, 0);
    // unit circle is a plus of five pixels
    add_row(OP_ERASE,   100,  100,   0,   1, 1'b1, 0, 5);
    // corner clamp, then the largest radius over most of the map
    add_row(OP_ERASE,     0,    0,   0,   2);
    add_row(OP_ERASE,   256,  128,   0, 255);
    add_row(OP_QUERY,     0,    0,   0,   0);

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i])
      send_request(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].want);

    // random part, idling phase rotates every 60 requests
    while (counted < RAND_REQS) begin
      idle_mode = idle_mode_t'((counted / 60) % 4);
      req = random_req();
      counted++;
      send_request(req, 1'b0, none);
    end
    in_valid  <= 1'b0;
    idle_mode = IDLE_NONE;

    // drain, then watch a little longer for stray results
    while (owed_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("covered %0d load, %0d erase, %0d query and %0d spare-code requests",
             n_load, n_erase, n_query, n_spare);
    $display("%0d pixels erased, %0d results checked, %0d mismatches, %0d cycles",
             pixels_erased, result_count, mismatch_count, cycles);
    if (mismatch_count == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule

@@ filelist.f @@
design/cebm_pkg.sv
design/circle_erase_bitmap_mask.sv
design/cebm_checker.sv
verif/circle_erase_bitmap_mask_tb.sv
